>>> rtl/scl_pkg.sv
// package for the sparse conv layer: sizes, action codes, fsm states, command structs
// no dependencies
`default_nettype none
package scl_pkg;
   localparam int MAX_IN_MAPS = 16;
   localparam int MAX_OUT_MAPS = 16;
   localparam int MAX_KERNEL_SIZE = 5;
   localparam int MAX_IN_SIZE = 36;
   localparam int SIGMOID_ENTRIES = 256;
   localparam int PIX_DEPTH = MAX_IN_MAPS * MAX_IN_SIZE * MAX_IN_SIZE;
   localparam int KER_DEPTH = MAX_OUT_MAPS * MAX_IN_MAPS * MAX_KERNEL_SIZE * MAX_KERNEL_SIZE;
   localparam int CON_DEPTH = MAX_OUT_MAPS * MAX_IN_MAPS;
   localparam int PIX_AW = $clog2(PIX_DEPTH);
   localparam int KER_AW = $clog2(KER_DEPTH);
   localparam int SIG_AW = $clog2(SIGMOID_ENTRIES);
   localparam int ACC_W = 40;

   localparam logic [2:0] ACT_PIXEL = 3'd0;
   localparam logic [2:0] ACT_WEIGHT = 3'd1;
   localparam logic [2:0] ACT_CONNECT = 3'd2;
   localparam logic [2:0] ACT_BIAS = 3'd3;
   localparam logic [2:0] ACT_SIGMOID = 3'd4;
   localparam logic [2:0] ACT_COMPUTE = 3'd5;

   localparam logic [2:0] REG_IN_MAPS = 3'd0;
   localparam logic [2:0] REG_OUT_MAPS = 3'd1;
   localparam logic [2:0] REG_KER_ROWS = 3'd2;
   localparam logic [2:0] REG_KER_COLS = 3'd3;
   localparam logic [2:0] REG_OUT_ROWS = 3'd4;
   localparam logic [2:0] REG_OUT_COLS = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_TAP, ST_DRAIN, ST_LOOKUP, ST_TABLE, ST_RESULT
   } state_type;

   typedef struct packed {
      logic capture;     // latch the request
      logic clear_acc;
      logic issue_tap;   // read pixel and weight for the current tap
      logic mac;         // accumulate the product available this cycle
      logic lookup;      // read the sigmoid table
      logic finish;      // form the result
   } cmd_type;

   typedef struct packed {
      logic range_err;
      logic tap_last;
      logic tap_skip;    // current map not connected
   } status_type;
endpackage
`default_nettype wire

>>> rtl/sparse_conv_layer_sigmoid_top.sv
// top level of the sparse conv layer with sigmoid lookup
// depends on scl_pkg, scl_ctrl, scl_datapath, scl_ram
//
// req channel: one beat per item; load beats are absorbed and give no rsp beat,
// actions 6 and 7 are dropped. a compute beat gives one rsp beat, formed by a
// check, a walk over the taps, a drain, a lookup and a table read; taps are one
// per unconnected map plus kernel_rows*kernel_cols per connected map in use
// (up to 400 for 16 maps of 5x5): one tap a cycle through a single multiply-
// accumulate fed by the pixel and weight memory ports. out-of-range computes
// go from the check straight to their rsp beat, with error set. in either case
// the next req beat is taken only once the rsp beat has been accepted.
// csr channel: always ready, index selects one of six size registers; write only
// while idle.
// reset clears the connection bits, the biases and the registers to their
// defaults; pixel, weight and table memories are not cleared.
// while rsp is stalled the result holds and req_ready stays low.
`default_nettype none
module sparse_conv_layer_sigmoid_top import scl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic [2:0]         req_action,
   input  wire logic [3:0]         req_out_map,
   input  wire logic [3:0]         req_in_map,
   input  wire logic [5:0]         req_row,
   input  wire logic [5:0]         req_col,
   input  wire logic signed [15:0] req_value,
   input  wire logic [7:0]         req_table_index,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic signed [15:0] rsp_pixel_value,
   output      logic               rsp_error,
   input  wire logic               csr_valid,
   output      logic               csr_ready,
   input  wire logic [2:0]         csr_index,
   input  wire logic [7:0]         csr_data
);
   cmd_type cmd;
   status_type status;
   assign csr_ready = 1'b1;

   scl_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_action, .req_ready,
      .rsp_valid, .rsp_ready, .status, .cmd);

   scl_datapath u_dp (
      .clock, .reset, .req_accept(req_valid && req_ready), .req_action, .req_out_map,
      .req_in_map, .req_row, .req_col, .req_value, .req_table_index,
      .csr_we(csr_valid), .csr_index, .csr_data, .cmd, .status,
      .rsp_pixel_value, .rsp_error);
endmodule
`default_nettype wire

>>> rtl/scl_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`default_nettype none
module scl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/scl_ctrl.sv
// controller fsm for the conv layer: sequences check, tap walk, lookup, result
// depends on scl_pkg
`default_nettype none
module scl_ctrl import scl_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [2:0] req_action,
   output      logic       req_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output      cmd_type    cmd
);
   state_type state_ff, state_in;
   logic take;
   assign take = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (take && req_action == ACT_COMPUTE) state_in = ST_CHECK;
         ST_CHECK:  state_in = status.range_err ? ST_RESULT : ST_TAP;
         ST_TAP:    if (status.tap_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_LOOKUP;
         ST_LOOKUP: state_in = ST_TABLE;
         ST_TABLE:  state_in = ST_RESULT;
         ST_RESULT: if (rsp_ready) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_RESULT);
      unique case (state_ff)
         ST_IDLE:   cmd.capture = take;
         ST_CHECK:  cmd.clear_acc = 1'b1;
         ST_TAP:    cmd.issue_tap = 1'b1;
         ST_DRAIN:  cmd.mac = 1'b1;
         ST_LOOKUP: cmd.lookup = 1'b1;
         ST_TABLE:  cmd.finish = 1'b1;
         default:   cmd = '0;
      endcase
      if (state_ff == ST_TAP) cmd.mac = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule
`default_nettype wire

>>> rtl/scl_datapath.sv
// datapath: stores, tap counters, multiply-accumulate, sigmoid lookup
// depends on scl_pkg and scl_ram
`default_nettype none
module scl_datapath import scl_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_accept,
   input  wire logic [2:0]         req_action,
   input  wire logic [3:0]         req_out_map,
   input  wire logic [3:0]         req_in_map,
   input  wire logic [5:0]         req_row,
   input  wire logic [5:0]         req_col,
   input  wire logic signed [15:0] req_value,
   input  wire logic [7:0]         req_table_index,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [7:0]         csr_data,
   input  wire cmd_type            cmd,
   output      status_type         status,
   output      logic signed [15:0] rsp_pixel_value,
   output      logic               rsp_error
);
   logic [4:0] nin_ff, nout_ff;
   logic [2:0] kr_ff, kc_ff;
   logic [5:0] orr_ff, oc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nin_ff <= 5'd1; nout_ff <= 5'd1; kr_ff <= 3'd5; kc_ff <= 3'd5;
         orr_ff <= 6'd28; oc_ff <= 6'd28;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_IN_MAPS:  nin_ff <= csr_data[4:0];
            REG_OUT_MAPS: nout_ff <= csr_data[4:0];
            REG_KER_ROWS: kr_ff <= csr_data[2:0];
            REG_KER_COLS: kc_ff <= csr_data[2:0];
            REG_OUT_ROWS: orr_ff <= csr_data[5:0];
            REG_OUT_COLS: oc_ff <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // clamped configuration
   logic [4:0] nin, nout;
   logic [2:0] kr, kc;
   logic [5:0] orr, oc, orr_max, oc_max;
   always_comb begin
      nin = (nin_ff == 5'd0) ? 5'd1 : (nin_ff > 5'(MAX_IN_MAPS)) ? 5'(MAX_IN_MAPS) : nin_ff;
      nout = (nout_ff == 5'd0) ? 5'd1 : (nout_ff > 5'(MAX_OUT_MAPS)) ? 5'(MAX_OUT_MAPS) : nout_ff;
      kr = (kr_ff == 3'd0) ? 3'd1 : (kr_ff > 3'(MAX_KERNEL_SIZE)) ? 3'(MAX_KERNEL_SIZE) : kr_ff;
      kc = (kc_ff == 3'd0) ? 3'd1 : (kc_ff > 3'(MAX_KERNEL_SIZE)) ? 3'(MAX_KERNEL_SIZE) : kc_ff;
      orr_max = 6'(MAX_IN_SIZE + 1) - 6'(kr);
      oc_max = 6'(MAX_IN_SIZE + 1) - 6'(kc);
      orr = (orr_ff == 6'd0) ? 6'd1 : (orr_ff > orr_max) ? orr_max : orr_ff;
      oc = (oc_ff == 6'd0) ? 6'd1 : (oc_ff > oc_max) ? oc_max : oc_ff;
   end

   // loads
   logic pix_we, ker_we, sig_we;
   logic [PIX_AW-1:0] pix_wa, pix_ra;
   logic [KER_AW-1:0] ker_wa, ker_ra;
   logic [SIG_AW-1:0] sig_ra;
   logic [15:0] pix_rd, ker_rd, sig_rd;
   logic [CON_DEPTH-1:0] con_ff;
   logic signed [15:0] bias_ff [MAX_OUT_MAPS];

   assign pix_we = req_accept && req_action == ACT_PIXEL && req_row < 6'(MAX_IN_SIZE)
                   && req_col < 6'(MAX_IN_SIZE);
   assign ker_we = req_accept && req_action == ACT_WEIGHT
                   && req_row < 6'(MAX_KERNEL_SIZE) && req_col < 6'(MAX_KERNEL_SIZE);
   assign sig_we = req_accept && req_action == ACT_SIGMOID;
   assign pix_wa = PIX_AW'((32'(req_in_map) * MAX_IN_SIZE + 32'(req_row)) * MAX_IN_SIZE
                   + 32'(req_col));
   assign ker_wa = KER_AW'(((32'(req_out_map) * MAX_IN_MAPS + 32'(req_in_map))
                   * MAX_KERNEL_SIZE + 32'(req_row)) * MAX_KERNEL_SIZE + 32'(req_col));

   always_ff @(posedge clock) begin
      if (reset) begin
         con_ff <= '0;
         for (int i = 0; i < MAX_OUT_MAPS; i++) bias_ff[i] <= '0;
      end else if (req_accept) begin
         if (req_action == ACT_CONNECT) con_ff[{req_out_map, req_in_map}] <= req_value[0];
         if (req_action == ACT_BIAS) bias_ff[req_out_map] <= req_value;
      end
   end

   scl_ram #(.WIDTH(16), .DEPTH(PIX_DEPTH)) u_pix (
      .clock, .wr_en(pix_we), .wr_addr(pix_wa), .wr_data(req_value),
      .rd_addr(pix_ra), .rd_data(pix_rd));
   scl_ram #(.WIDTH(16), .DEPTH(KER_DEPTH)) u_ker (
      .clock, .wr_en(ker_we), .wr_addr(ker_wa), .wr_data(req_value),
      .rd_addr(ker_ra), .rd_data(ker_rd));
   scl_ram #(.WIDTH(16), .DEPTH(SIGMOID_ENTRIES)) u_sig (
      .clock, .wr_en(sig_we), .wr_addr(req_table_index), .wr_data(req_value),
      .rd_addr(sig_ra), .rd_data(sig_rd));

   // captured compute request
   logic [3:0] om_ff;
   logic [5:0] r_ff, c_ff;
   logic [3:0] j_ff, j_in;
   logic [2:0] a_ff, a_in, b_ff, b_in;
   logic       err_ff;
   logic       vld_ff;         // read issued last cycle for a connected tap
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         om_ff <= req_out_map; r_ff <= req_row; c_ff <= req_col;
      end
   end

   assign status.range_err = (5'(om_ff) >= nout) || (r_ff >= orr) || (c_ff >= oc);
   assign status.tap_skip = !con_ff[{om_ff, j_ff}];
   logic map_last;
   assign map_last = (5'(j_ff) == nin - 5'd1);
   assign status.tap_last = map_last && (status.tap_skip || (a_ff == kr - 3'd1
                            && b_ff == kc - 3'd1));

   always_comb begin
      j_in = j_ff; a_in = a_ff; b_in = b_ff;
      if (cmd.clear_acc) begin
         j_in = '0; a_in = '0; b_in = '0;
      end else if (cmd.issue_tap) begin
         if (status.tap_skip || (a_ff == kr - 3'd1 && b_ff == kc - 3'd1)) begin
            j_in = j_ff + 4'd1; a_in = '0; b_in = '0;
         end else if (b_ff == kc - 3'd1) begin
            a_in = a_ff + 3'd1; b_in = '0;
         end else begin
            b_in = b_ff + 3'd1;
         end
      end
   end

   assign pix_ra = PIX_AW'((32'(j_ff) * MAX_IN_SIZE + 32'(r_ff) + 32'(a_ff)) * MAX_IN_SIZE
                   + 32'(c_ff) + 32'(b_ff));
   assign ker_ra = KER_AW'(((32'(om_ff) * MAX_IN_MAPS + 32'(j_ff)) * MAX_KERNEL_SIZE
                   + 32'(a_ff)) * MAX_KERNEL_SIZE + 32'(b_ff));

   logic signed [31:0] prod;
   assign prod = $signed(pix_rd) * $signed(ker_rd);

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= cmd.issue_tap && !status.tap_skip;
      j_ff <= j_in; a_ff <= a_in; b_ff <= b_in;
      if (cmd.clear_acc) begin
         acc_ff <= '0;
         err_ff <= status.range_err;
      end else if (cmd.mac && vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod);
      end
   end

   // clamp and index
   always_comb begin
      if (acc_ff < -ACC_W'(524288)) sig_ra = '0;
      else if (acc_ff > ACC_W'(524287)) sig_ra = '1;
      else sig_ra = SIG_AW'((acc_ff + ACC_W'(524288)) >>> 12);
   end

   logic signed [16:0] sum;
   assign sum = 17'(signed'(sig_rd)) + 17'(bias_ff[om_ff]);
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_pixel_value <= (sum > 17'sd32767) ? 16'sh7fff
                          : (sum < -17'sd32768) ? 16'sh8000 : sum[15:0];
      end else if (cmd.clear_acc && status.range_err) begin
         rsp_pixel_value <= '0;
      end
   end
   assign rsp_error = err_ff;
endmodule
`default_nettype wire

>>> rtl/scl_checker.sv
// port-level checks for the conv layer top
// depends on scl_pkg and sparse_conv_layer_sigmoid_top ports, bound below
`default_nettype none
module scl_checker import scl_pkg::*; (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [2:0]  req_action,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_pixel_value,
   input wire logic        rsp_error
);
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken with result pending");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_pixel_value == 16'd0) else $error("error with value");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value))
      else $error("result dropped");
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action != ACT_COMPUTE |=> !rsp_valid && req_ready)
      else $error("load produced a result");
endmodule

bind sparse_conv_layer_sigmoid_top scl_checker u_scl_checker (
   .clock, .reset, .req_valid, .req_ready, .req_action, .rsp_valid, .rsp_ready,
   .rsp_pixel_value, .rsp_error);
`default_nettype wire
